### hw/rtl/grl_pkg.sv
// shared constants and types for the graph level ranking unit
package grl_pkg;

    localparam int MAX_VERTICES          = 256;
    localparam int MAX_SUCCESSOR_ENTRIES = 1024;

    localparam int VTX_W  = 9;   // vertex number, 0..256
    localparam int VADR_W = 8;   // vertex memory address, vertex - 1
    localparam int POS_W  = 10;  // successor-list position
    localparam int VAL_W  = 11;  // stored successor or start value
    localparam int DEG_W  = 10;  // in-degree count

    typedef enum logic [1:0] {
        CMD_LOAD_SUCC  = 2'd0,
        CMD_LOAD_START = 2'd1,
        CMD_COMPUTE    = 2'd2,
        CMD_READ_RANK  = 2'd3
    } t_cmd;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_SUCC_LENGTH  = 2'd1;

    localparam logic signed [VTX_W-1:0] RANK_NONE = -9'sd1;

endpackage

### hw/rtl/graph_rank_levels_unit.sv
// graph level ranking unit: graph stores, rank sequencer and command interface
//
// Load commands (successor entry, start index) give no reply. A rank read's reply
// strobes on o_valid in the next cycle; reads may be issued back to back. A compute
// request holds busy high while the sequencer walks the stores through memories with
// one write port and a registered read port: it clears the in-degree memory, counts
// in-degrees over the successor-list positions, seeds the stack with the vertices of
// zero in-degree, then opens level after level, and for each ranked vertex reads its
// successor entries up to the ending zero and lowers the in-degree of each successor
// that names a vertex; last it checks that all vertices were ranked and posts the
// reply. The compute reply strobes once when busy falls. Replies cannot be held off
// by the receiver. Configuration writes are always accepted (o_cfg_ready stays high)
// and are meant to happen only while the unit is idle.
module graph_rank_levels_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command request
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_command,
    input  logic [grl_pkg::POS_W-1:0]            i_index,
    input  logic [grl_pkg::VAL_W-1:0]            i_value,
    // reply
    output logic                                 o_valid,
    output logic [grl_pkg::VTX_W-1:0]            o_vertex,
    output logic signed [grl_pkg::VTX_W-1:0]     o_rank,
    output logic [grl_pkg::VTX_W-1:0]            o_level_count,
    output logic                                 o_acyclic,
    // configuration write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [grl_pkg::POS_W-1:0]            i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CNT_RD, S_CNT_IDX, S_CNT_WR, S_PSH_RD, S_PSH_CHK,
        S_LV_TOP, S_VX, S_VX_H, S_SR, S_SD, S_DG, S_LK, S_SCAN, S_DONE
    } t_state;

    localparam int VTX_W  = grl_pkg::VTX_W;
    localparam int VADR_W = grl_pkg::VADR_W;
    localparam int POS_W  = grl_pkg::POS_W;
    localparam int VAL_W  = grl_pkg::VAL_W;
    localparam int DEG_W  = grl_pkg::DEG_W;

    // memories
    logic [VAL_W-1:0]  r_succ_mem  [grl_pkg::MAX_SUCCESSOR_ENTRIES];
    logic [VAL_W-1:0]  r_start_mem [grl_pkg::MAX_VERTICES];
    logic [DEG_W-1:0]  r_deg_mem   [grl_pkg::MAX_VERTICES];
    logic [VTX_W-1:0]  r_link_mem  [grl_pkg::MAX_VERTICES];
    logic [VTX_W-1:0]  r_rank_mem  [grl_pkg::MAX_VERTICES];
    logic [grl_pkg::MAX_VERTICES-1:0] r_rvalid;

    logic [VAL_W-1:0]  r_succ_q, r_start_q;
    logic [DEG_W-1:0]  r_deg_q;
    logic [VTX_W-1:0]  r_link_q, r_rank_q;

    // control state
    t_state            r_state;
    logic [VTX_W-1:0]  r_vcount;
    logic [POS_W-1:0]  r_slen;
    logic [VADR_W-1:0] r_clr;
    logic [POS_W-1:0]  r_pos;
    logic [VTX_W-1:0]  r_s;
    logic [VAL_W-1:0]  r_t;
    logic [VAL_W-1:0]  r_h;
    logic              r_hok;
    logic [VTX_W-1:0]  r_head;
    logic [VTX_W-1:0]  r_lvl;
    logic              r_ok;
    logic [VTX_W-1:0]  r_levels;
    logic              r_all;
    logic              r_cmp_done;
    logic              r_rd_pend;
    logic              r_rd_ok;
    logic              r_rd_vld;
    logic [VTX_W-1:0]  r_rd_vtx;

    // memory port controls
    logic              succ_we, start_we, deg_we, link_we, rank_we;
    logic [POS_W-1:0]  succ_wa, succ_ra;
    logic [VADR_W-1:0] start_wa, start_ra, deg_wa, deg_ra, link_wa, link_ra;
    logic [VADR_W-1:0] rank_wa, rank_ra;
    logic [VAL_W-1:0]  succ_wd, start_wd;
    logic [DEG_W-1:0]  deg_wd;
    logic [VTX_W-1:0]  link_wd, rank_wd;

    logic              accept;
    logic [VTX_W-1:0]  n_act;
    logic [VAL_W-1:0]  t_cur;
    logic              idx_in_range;
    logic [VADR_W-1:0] s_adr, t_adr;

    assign accept       = start && !busy;
    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign n_act        = (r_vcount > VTX_W'(grl_pkg::MAX_VERTICES))
                          ? VTX_W'(grl_pkg::MAX_VERTICES) : r_vcount;
    assign t_cur        = r_hok ? r_succ_q : '0;
    assign idx_in_range = (i_index != '0) && (i_index <= POS_W'(n_act));
    assign s_adr        = VADR_W'(r_s - VTX_W'(1));
    assign t_adr        = VADR_W'(r_t - VAL_W'(1));

    // memory port steering
    always_comb begin
        succ_we  = 1'b0; succ_wa  = i_index; succ_wd = i_value; succ_ra = r_pos;
        start_we = 1'b0; start_wa = VADR_W'(i_index - POS_W'(1)); start_wd = i_value;
        start_ra = s_adr;
        deg_we   = 1'b0; deg_wa   = r_clr; deg_wd = '0; deg_ra = s_adr;
        link_we  = 1'b0; link_wa  = s_adr; link_wd = r_head; link_ra = s_adr;
        rank_we  = 1'b0; rank_wa  = s_adr; rank_wd = VTX_W'(r_lvl - VTX_W'(1));
        rank_ra  = VADR_W'(i_index - POS_W'(1));
        case (r_state)
            S_IDLE: begin
                if (accept && i_command == grl_pkg::CMD_LOAD_SUCC) begin
                    succ_we = 1'b1;
                end
                if (accept && i_command == grl_pkg::CMD_LOAD_START && i_index != '0
                    && i_index <= POS_W'(grl_pkg::MAX_VERTICES)) begin
                    start_we = 1'b1;
                end
            end
            S_CLR: begin
                deg_we = 1'b1;
            end
            S_CNT_IDX: begin
                deg_ra = VADR_W'(r_succ_q - VAL_W'(1));
            end
            S_CNT_WR: begin
                deg_we = 1'b1;
                deg_wa = t_adr;
                deg_wd = r_deg_q + DEG_W'(1);
            end
            S_PSH_CHK: begin
                link_we = (r_deg_q == '0);
            end
            S_VX: begin
                rank_we = (r_s != '0) && (r_s <= n_act);
            end
            S_SR: begin
                succ_ra = r_h[POS_W-1:0];
            end
            S_SD: begin
                deg_ra = VADR_W'(t_cur - VAL_W'(1));
            end
            S_DG: begin
                deg_we  = (r_deg_q != '0);
                deg_wa  = t_adr;
                deg_wd  = r_deg_q - DEG_W'(1);
                link_we = (r_deg_q == DEG_W'(1));
                link_wa = t_adr;
            end
            default: begin
            end
        endcase
    end

    // successor memory
    always_ff @(posedge i_clk) begin
        if (succ_we) begin
            r_succ_mem[succ_wa] <= succ_wd;
        end
        r_succ_q <= r_succ_mem[succ_ra];
    end

    // start index memory
    always_ff @(posedge i_clk) begin
        if (start_we) begin
            r_start_mem[start_wa] <= start_wd;
        end
        r_start_q <= r_start_mem[start_ra];
    end

    // in-degree memory
    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            r_deg_mem[deg_wa] <= deg_wd;
        end
        r_deg_q <= r_deg_mem[deg_ra];
    end

    // stack link memory
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        r_link_q <= r_link_mem[link_ra];
    end

    // rank memory
    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_rank_mem[rank_wa] <= rank_wd;
        end
        r_rank_q <= r_rank_mem[rank_ra];
    end

    // sequencer, configuration and reply registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcount   <= VTX_W'(1);
            r_slen     <= '0;
            r_rvalid   <= '0;
            r_head     <= '0;
            r_lvl      <= '0;
            r_ok       <= 1'b0;
            r_levels   <= '0;
            r_all      <= 1'b0;
            r_cmp_done <= 1'b0;
            r_rd_pend  <= 1'b0;
            r_rd_ok    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_vtx   <= '0;
            r_clr      <= '0;
            r_pos      <= '0;
            r_s        <= '0;
            r_t        <= '0;
            r_h        <= '0;
            r_hok      <= 1'b0;
        end else begin
            r_cmp_done <= 1'b0;
            r_rd_pend  <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == grl_pkg::CFG_VERTEX_COUNT) begin
                    r_vcount <= i_cfg_data[VTX_W-1:0];
                end else if (i_cfg_index == grl_pkg::CFG_SUCC_LENGTH) begin
                    r_slen <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_command == grl_pkg::CMD_READ_RANK) begin
                        r_rd_pend <= 1'b1;
                        r_rd_ok   <= idx_in_range;
                        r_rd_vtx  <= idx_in_range ? i_index[VTX_W-1:0] : '0;
                        r_rd_vld  <= r_rvalid[VADR_W'(i_index - POS_W'(1))];
                    end
                    if (accept && i_command == grl_pkg::CMD_COMPUTE) begin
                        r_state  <= S_CLR;
                        r_clr    <= '0;
                        r_rvalid <= '0;
                        r_head   <= '0;
                        r_lvl    <= '0;
                    end
                end
                // zero every in-degree
                S_CLR: begin
                    r_clr <= r_clr + VADR_W'(1);
                    if (r_clr == '1) begin
                        r_pos   <= POS_W'(1);
                        r_s     <= VTX_W'(1);
                        r_state <= (r_slen == '0) ? S_PSH_RD : S_CNT_RD;
                    end
                end
                // count in-degrees over the successor list
                S_CNT_RD: begin
                    r_state <= S_CNT_IDX;
                end
                S_CNT_IDX: begin
                    r_t <= r_succ_q;
                    if (r_succ_q != '0 && r_succ_q <= VAL_W'(n_act)) begin
                        r_state <= S_CNT_WR;
                    end else if (r_pos == r_slen) begin
                        r_state <= S_PSH_RD;
                    end else begin
                        r_pos   <= r_pos + POS_W'(1);
                        r_state <= S_CNT_RD;
                    end
                end
                S_CNT_WR: begin
                    if (r_pos == r_slen) begin
                        r_state <= S_PSH_RD;
                    end else begin
                        r_pos   <= r_pos + POS_W'(1);
                        r_state <= S_CNT_RD;
                    end
                end
                // seed the stack with zero in-degree vertices
                S_PSH_RD: begin
                    r_state <= (n_act == '0) ? S_LV_TOP : S_PSH_CHK;
                end
                S_PSH_CHK: begin
                    if (r_deg_q == '0) begin
                        r_head <= r_s;
                    end
                    if (r_s == n_act) begin
                        r_state <= S_LV_TOP;
                    end else begin
                        r_s     <= r_s + VTX_W'(1);
                        r_state <= S_PSH_RD;
                    end
                end
                // open the next level or finish
                S_LV_TOP: begin
                    if (r_head == '0) begin
                        r_ok    <= 1'b1;
                        r_s     <= VTX_W'(1);
                        r_state <= (n_act == '0) ? S_DONE : S_SCAN;
                    end else begin
                        r_lvl   <= r_lvl + VTX_W'(1);
                        r_s     <= r_head;
                        r_head  <= '0;
                        r_state <= S_VX;
                    end
                end
                // rank one vertex of the level
                S_VX: begin
                    if (r_s != '0 && r_s <= n_act) begin
                        r_rvalid[s_adr] <= 1'b1;
                        r_state         <= S_VX_H;
                    end else begin
                        r_state <= S_LV_TOP;
                    end
                end
                S_VX_H: begin
                    r_h     <= r_start_q;
                    r_state <= S_SR;
                end
                // walk the vertex successor group
                S_SR: begin
                    r_hok   <= (r_h != '0) && (r_h <= VAL_W'(r_slen));
                    r_state <= S_SD;
                end
                S_SD: begin
                    r_t <= t_cur;
                    if (t_cur == '0) begin
                        r_state <= S_LK;
                    end else if (t_cur <= VAL_W'(n_act)) begin
                        r_state <= S_DG;
                    end else begin
                        r_h     <= r_h + VAL_W'(1);
                        r_state <= S_SR;
                    end
                end
                S_DG: begin
                    if (r_deg_q == DEG_W'(1)) begin
                        r_head <= r_t[VTX_W-1:0];
                    end
                    r_h     <= r_h + VAL_W'(1);
                    r_state <= S_SR;
                end
                S_LK: begin
                    r_s     <= r_link_q;
                    r_state <= S_VX;
                end
                // check that every vertex got a rank
                S_SCAN: begin
                    if (!r_rvalid[s_adr]) begin
                        r_ok <= 1'b0;
                    end
                    if (r_s == n_act) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s <= r_s + VTX_W'(1);
                    end
                end
                S_DONE: begin
                    r_levels   <= r_lvl;
                    r_all      <= r_ok;
                    r_cmp_done <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // reply
    assign o_valid       = r_rd_pend || r_cmp_done;
    assign o_vertex      = r_cmp_done ? '0 : r_rd_vtx;
    assign o_rank        = r_cmp_done ? '0
                         : ((r_rd_ok && r_rd_vld) ? $signed(r_rank_q) : grl_pkg::RANK_NONE);
    assign o_level_count = r_levels;
    assign o_acyclic     = r_all;

endmodule
